@@ rtl/core/mst_pkg.sv @@
// Shared types and constants for the station sighting table.
package mst_pkg;

	localparam int TABLE_DEPTH_DEF = 32;
	localparam int NAME_WORDS      = 4;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		OP_OBSERVE = 2'd0,
		OP_READ    = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_IGNORE  = 2'd3
	} op_e;

	typedef enum logic [2:0] {
		ST_HIT       = 3'd0,
		ST_INSERTED  = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_READ_OK   = 3'd3,
		ST_READ_OOR  = 3'd4,
		ST_CLEARED   = 3'd5
	} status_e;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEARCH,
		BK_UPDATE,
		BK_READ
	} back_state_e;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [47:0] station_addr;
		logic [63:0] name_word0;
		logic [63:0] name_word1;
		logic [63:0] name_word2;
		logic [63:0] name_word3;
		logic [31:0] now_ms;
		logic [7:0]  read_index;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  entry_index;
		logic [5:0]  entries_used;
		logic [47:0] entry_addr;
		logic [31:0] entry_hits;
		logic [31:0] entry_last_ms;
		logic [63:0] entry_name0;
		logic [63:0] entry_name1;
		logic [63:0] entry_name2;
		logic [63:0] entry_name3;
	} result_t;

	// classified command between front and back; name words already cleaned
	typedef struct packed {
		op_e                          op;
		logic [47:0]                  addr;
		logic [NAME_WORDS-1:0][63:0]  name;
		logic                         has_name;
		logic [31:0]                  now_ms;
		logic [7:0]                   read_index;
	} cmd_t;

	typedef struct packed {
		logic [47:0]                  addr;
		logic [31:0]                  hits;
		logic [31:0]                  last_ms;
		logic [NAME_WORDS-1:0][63:0]  name;
	} entry_t;

	typedef struct packed {
		logic push;
		logic full;
	} queue_ctl_t;

endpackage

@@ rtl/core/mst_front.sv @@
// Front end: takes requests, drops ignored opcodes, cleans the name and queues the command.
module mst_front
	import mst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  request_t   request,
	input  logic       q_full,
	output logic       q_push,
	output cmd_t       q_cmd
);

	logic   cmd_vld_s1;
	cmd_t   cmd_s1;
	logic   accept;
	logic   load;
	cmd_t   cmd_new;

	// zero every byte from the first zero byte onwards; byte 0 sits in the top word
	function automatic logic [NAME_WORDS-1:0][63:0] clean_name(
		input logic [NAME_WORDS-1:0][63:0] raw
	);
		logic [NAME_WORDS-1:0][63:0] res;
		logic                        ended;
		ended = 1'b0;
		res   = '0;
		for (int w = NAME_WORDS - 1; w >= 0; w--) begin
			for (int b = 0; b < 8; b++) begin
				if (raw[w][63-8*b -: 8] == 8'd0)
					ended = 1'b1;
				if (!ended)
					res[w][63-8*b -: 8] = raw[w][63-8*b -: 8];
			end
		end
		return res;
	endfunction

	assign busy   = cmd_vld_s1 & q_full;
	assign accept = start & ~busy;
	assign load   = accept & (op_e'(request.opcode) != OP_IGNORE);
	assign q_push = cmd_vld_s1 & ~q_full;
	assign q_cmd  = cmd_s1;

	always_comb begin
		cmd_new.op         = op_e'(request.opcode);
		cmd_new.addr       = request.station_addr;
		cmd_new.name       = clean_name({request.name_word0, request.name_word1,
			request.name_word2, request.name_word3});
		cmd_new.has_name   = (request.name_word0[63:56] != 8'd0);
		cmd_new.now_ms     = request.now_ms;
		cmd_new.read_index = request.read_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_s1 <= 1'b0;
		end else if (load) begin
			cmd_vld_s1 <= 1'b1;
		end else if (q_push) begin
			cmd_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1 <= cmd_new;
		end
	end

endmodule

@@ rtl/core/mst_queue.sv @@
// Short command queue between front and back.
module mst_queue
	import mst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  queue_ctl_t  ctl_in,
	input  cmd_t        push_cmd,
	output logic        full,
	input  logic        pop,
	output logic        vld,
	output cmd_t        head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign vld     = (count_q != '0);
	assign head    = slot_q[rd_ptr_q];
	assign do_push = ctl_in.push & ~ctl_in.full;
	assign do_pop  = pop & vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ rtl/core/mst_back.sv @@
// Back end: table memory, sequential address search, update and result register.
module mst_back
	import mst_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_vld,
	input  cmd_t     q_cmd,
	output logic     q_pop,
	output logic     done,
	output result_t  result
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W = (FILL_W > 8) ? FILL_W : 8;

	entry_t           mem [TABLE_DEPTH];
	entry_t           rdata_q;
	logic [IDX_W-1:0] rd_idx;
	logic             we;
	entry_t           wdata;

	back_state_e      state_q, state_d;
	cmd_t             cur_q, cur_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [FILL_W-1:0] scan_q, scan_d;
	logic             pend_vld_q, pend_vld_d;
	logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
	entry_t           ent_q, ent_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             ins_q, ins_d;
	logic             done_q, done_d;
	result_t          result_q, result_d;

	logic             match;
	entry_t           ent_upd;
	logic [CMP_W-1:0] ri_ext;
	logic [CMP_W-1:0] fill_ext;
	logic [CMP_W-1:0] cur_ri_ext;
	logic [FILL_W+5:0] used_wide;
	logic [IDX_W+4:0] idx_wide;
	logic [IDX_W+4:0] ri_wide;

	assign q_pop  = (state_q == BK_IDLE) & q_vld;
	assign done   = done_q;
	assign result = result_q;

	assign match      = pend_vld_q & (rdata_q.addr == cur_q.addr);
	assign ri_ext     = CMP_W'(q_cmd.read_index);
	assign cur_ri_ext = CMP_W'(cur_q.read_index);
	assign fill_ext   = CMP_W'(fill_q);
	assign used_wide  = {6'd0, fill_q};
	assign idx_wide   = {5'd0, idx_q};
	assign ri_wide    = {5'd0, cur_ri_ext[IDX_W-1:0]};

	always_comb begin
		ent_upd         = ent_q;
		ent_upd.hits    = (ent_q.hits == 32'hFFFF_FFFF) ? ent_q.hits : ent_q.hits + 32'd1;
		ent_upd.last_ms = cur_q.now_ms;
		if (cur_q.has_name)
			ent_upd.name = cur_q.name;
	end

	always_comb begin
		state_d    = state_q;
		cur_d      = cur_q;
		fill_d     = fill_q;
		scan_d     = scan_q;
		pend_vld_d = 1'b0;
		pend_idx_d = pend_idx_q;
		ent_d      = ent_q;
		idx_d      = idx_q;
		ins_d      = ins_q;
		done_d     = 1'b0;
		result_d   = result_q;
		rd_idx     = scan_q[IDX_W-1:0];
		we         = 1'b0;
		wdata      = ent_upd;

		case (state_q)
			BK_IDLE: begin
				if (q_vld) begin
					cur_d = q_cmd;
					case (q_cmd.op)
						OP_OBSERVE: begin
							scan_d  = '0;
							state_d = BK_SEARCH;
						end
						OP_READ: begin
							rd_idx = ri_ext[IDX_W-1:0];
							if (ri_ext < fill_ext) begin
								state_d = BK_READ;
							end else begin
								done_d                = 1'b1;
								result_d              = '0;
								result_d.status       = ST_READ_OOR;
								result_d.entries_used = used_wide[5:0];
							end
						end
						OP_CLEAR: begin
							fill_d          = '0;
							done_d          = 1'b1;
							result_d        = '0;
							result_d.status = ST_CLEARED;
						end
						default: begin
						end
					endcase
				end
			end
			BK_SEARCH: begin
				if (match) begin
					ent_d   = rdata_q;
					idx_d   = pend_idx_q;
					ins_d   = 1'b0;
					state_d = BK_UPDATE;
				end else if (scan_q == fill_q) begin
					if (fill_q == FILL_W'(TABLE_DEPTH)) begin
						done_d                = 1'b1;
						result_d              = '0;
						result_d.status       = ST_DROPPED;
						result_d.entries_used = used_wide[5:0];
						state_d               = BK_IDLE;
					end else begin
						ent_d      = '0;
						ent_d.addr = cur_q.addr;
						idx_d      = fill_q[IDX_W-1:0];
						fill_d     = fill_q + 1'b1;
						ins_d      = 1'b1;
						state_d    = BK_UPDATE;
					end
				end else begin
					pend_vld_d = 1'b1;
					pend_idx_d = scan_q[IDX_W-1:0];
					scan_d     = scan_q + 1'b1;
				end
			end
			BK_UPDATE: begin
				we                     = 1'b1;
				done_d                 = 1'b1;
				result_d.status        = ins_q ? ST_INSERTED : ST_HIT;
				result_d.entry_index   = idx_wide[4:0];
				result_d.entries_used  = used_wide[5:0];
				result_d.entry_addr    = ent_upd.addr;
				result_d.entry_hits    = ent_upd.hits;
				result_d.entry_last_ms = ent_upd.last_ms;
				result_d.entry_name0   = ent_upd.name[3];
				result_d.entry_name1   = ent_upd.name[2];
				result_d.entry_name2   = ent_upd.name[1];
				result_d.entry_name3   = ent_upd.name[0];
				state_d                = BK_IDLE;
			end
			BK_READ: begin
				done_d                 = 1'b1;
				result_d.status        = ST_READ_OK;
				result_d.entry_index   = ri_wide[4:0];
				result_d.entries_used  = used_wide[5:0];
				result_d.entry_addr    = rdata_q.addr;
				result_d.entry_hits    = rdata_q.hits;
				result_d.entry_last_ms = rdata_q.last_ms;
				result_d.entry_name0   = rdata_q.name[3];
				result_d.entry_name1   = rdata_q.name[2];
				result_d.entry_name2   = rdata_q.name[1];
				result_d.entry_name3   = rdata_q.name[0];
				state_d                = BK_IDLE;
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			fill_q     <= '0;
			pend_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			fill_q     <= fill_d;
			pend_vld_q <= pend_vld_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= cur_d;
		scan_q     <= scan_d;
		pend_idx_q <= pend_idx_d;
		ent_q      <= ent_d;
		idx_q      <= idx_d;
		ins_q      <= ins_d;
		result_q   <= result_d;
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[idx_q] <= wdata;
		rdata_q <= mem[rd_idx];
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(TABLE_DEPTH))
		else $error("fill level beyond table depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_SEARCH |-> scan_q <= fill_q)
		else $error("search ran past filled entries");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		we |=> done_q && (result_q.status == ST_HIT || result_q.status == ST_INSERTED))
		else $error("table write without hit or insert result");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status == ST_DROPPED |-> fill_q == FILL_W'(TABLE_DEPTH))
		else $error("dropped while table not full");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && result_q.status == ST_CLEARED |-> fill_q == '0)
		else $error("table not empty after clear");

endmodule

@@ rtl/core/mac_sighting_table_top.sv @@
// Top level of the station address sighting table with hit counters.
//
// Request channel: a request is taken at a rising edge where start is high and
// busy is low. Opcode observe looks the address up, inserting it on a miss;
// read returns one entry by index; clear empties the table; opcode three is
// taken and ignored, with no result.
// Result channel: every other request gives exactly one result, shown on
// result for the single cycle in which done is high. The receiver cannot stall.
// Structure: the front registers and cleans each request and hands it to a
// two-deep command queue; the back pops it and works on it against the table
// memory (one write and one registered read port).
// Search: an observe on a table holding n entries reads its filled entries in
// order, one memory entry per cycle, and stops at the first address match; on a
// miss it inserts the address, or drops it when all entries are filled. An
// in-range read goes through the registered memory read port; an out-of-range
// read and a clear give their result straight from idle. The front takes
// further requests while the back works, raising busy only when its stage and
// the queue are both full.
// Reset: arst_n empties the table and the queue; no memory clearing pass is
// needed since only filled entries are ever read.
module mac_sighting_table_top
	import mst_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	queue_ctl_t q_ctl;
	cmd_t       front_cmd;
	cmd_t       head_cmd;
	logic       q_full;
	logic       q_push;
	logic       q_vld;
	logic       q_pop;

	assign q_ctl.push = q_push;
	assign q_ctl.full = q_full;

	mst_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_cmd   (front_cmd)
	);

	mst_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (q_ctl),
		.push_cmd (front_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.vld      (q_vld),
		.head     (head_cmd)
	);

	mst_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_cmd  (head_cmd),
		.q_pop  (q_pop),
		.done   (done),
		.result (result)
	);

endmodule
